[rtl/tes_pkg.sv]
package tes_pkg;

	localparam int unsigned OUT_HIGH_BITS = 24;

	localparam logic [7:0] BOM_BYTE0 = 8'hEF;
	localparam logic [7:0] BOM_BYTE1 = 8'hBB;
	localparam logic [7:0] BOM_BYTE2 = 8'hBF;
	localparam logic [1:0] BOM_LEN   = 2'd3;

	// Pair flag positions
	localparam int unsigned FLAG_GBK     = 0;
	localparam int unsigned FLAG_BIG5    = 1;
	localparam int unsigned FLAG_SJIS    = 2;
	localparam int unsigned FLAG_WESTERN = 3;

	typedef enum logic [2:0] {
		ENC_UTF8_BOM   = 3'd0,
		ENC_UTF8       = 3'd1,
		ENC_FEW_HIGH   = 3'd2,
		ENC_GBK        = 3'd3,
		ENC_BIG5       = 3'd4,
		ENC_SJIS       = 3'd5,
		ENC_WIN1252    = 3'd6,
		ENC_SYS_DEFAULT = 3'd7
	} encoding_t;

	// Cap on the second byte of a multi-byte UTF-8 sequence
	typedef enum logic [1:0] {
		LIM_NONE = 2'd0,
		LIM_9F   = 2'd1,
		LIM_8F   = 2'd2
	} limit_t;

	function automatic logic [7:0] bom_byte(input logic [1:0] idx);
		logic [7:0] b;
		begin
			unique case (idx)
				2'd0:    b = BOM_BYTE0;
				2'd1:    b = BOM_BYTE1;
				default: b = BOM_BYTE2;
			endcase
			return b;
		end
	endfunction

	// Classify one byte pair; first matching rule wins, at most one bit set
	function automatic logic [3:0] pair_flag(input logic [7:0] a, input logic [7:0] b);
		logic       b_gbk;
		logic       b_low;
		logic [3:0] f;
		begin
			b_gbk = (b >= 8'hA1) && (b <= 8'hFE);
			b_low = (b >= 8'h40) && (b <= 8'h7E);
			f = 4'b0000;
			if ((a >= 8'hA1) && (a <= 8'hF7) && b_gbk) begin
				f[FLAG_GBK] = 1'b1;
			end else if ((a >= 8'hA1) && (a <= 8'hF9) && (b_low || b_gbk)) begin
				f[FLAG_BIG5] = 1'b1;
			end else if (((a >= 8'h81) && (a <= 8'h9F)) || ((a >= 8'hE0) && (a <= 8'hFC))) begin
				if (b_low || ((b >= 8'h80) && (b <= 8'hFC))) begin
					f[FLAG_SJIS] = 1'b1;
				end
			end else if ((a >= 8'hC0) && (b >= 8'h80)) begin
				f[FLAG_WESTERN] = 1'b1;
			end
			return f;
		end
	endfunction

endpackage

[rtl/text_encoding_sniffer.sv]
// Path: the last byte of a file passes the input register; the stage-2 capture of the file
// figures and the ratio compare into the output register then put its verdict on m_axis.
// Throughput: one byte per cycle; the only stall is a second verdict reaching the
// output while the previous one still waits on m_axis_tready.
// Reset: arst_n clears all per-file state and valid flags; the state also returns to
// zero by itself after every last byte.
module text_encoding_sniffer #(
	parameter int unsigned COUNT_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// Byte stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	// Verdict out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [2:0] encoding_class, [3] utf8_valid,
	                                    // [27:4] high_byte_total, [31:28] zero
);

	localparam int unsigned PROD_BITS = COUNT_BITS + 7;

	// ---------------------------------------------------------------
	// Flow control: everything advances unless a finished verdict in
	// stage 2 has nowhere to go.
	// ---------------------------------------------------------------
	logic stall;
	logic res_s2;
	logic out_vld_q;

	assign stall         = res_s2 && out_vld_q && !m_axis_tready;
	assign s_axis_tready = !stall;

	// ---------------------------------------------------------------
	// Stage 1: input register
	// ---------------------------------------------------------------
	logic       vld_s1;
	logic       last_s1;
	logic [7:0] byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!stall) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// ---------------------------------------------------------------
	// Per-file state
	// ---------------------------------------------------------------
	logic [7:0]            prev_byte_q;
	logic [COUNT_BITS-1:0] byte_total_q;
	logic [COUNT_BITS-1:0] high_total_q;
	logic [1:0]            cont_left_q;
	tes_pkg::limit_t       limit_q;
	logic                  broken_q;
	logic [1:0]            bom_prog_q;
	logic [3:0]            flags_q;

	logic [COUNT_BITS-1:0] byte_total_d;
	logic [COUNT_BITS-1:0] high_total_d;
	logic [1:0]            cont_left_d;
	tes_pkg::limit_t       limit_d;
	logic                  broken_d;
	logic [1:0]            bom_prog_d;
	logic [3:0]            flags_d;
	logic                  take;

	assign take = vld_s1 && !stall;

	always_comb begin
		byte_total_d = byte_total_q;
		high_total_d = high_total_q;
		cont_left_d  = cont_left_q;
		limit_d      = limit_q;
		broken_d     = broken_q;
		bom_prog_d   = bom_prog_q;
		flags_d      = flags_q;

		// BOM matcher: only while every byte so far has matched
		if ((byte_total_q < COUNT_BITS'(3)) && (bom_prog_q == byte_total_q[1:0]) &&
		    (byte_s1 == tes_pkg::bom_byte(byte_total_q[1:0]))) begin
			bom_prog_d = bom_prog_q + 2'd1;
		end

		// Byte pairs need a predecessor within this file
		if (byte_total_q != '0) begin
			flags_d = flags_q | tes_pkg::pair_flag(prev_byte_q, byte_s1);
		end

		// UTF-8 checker
		if (cont_left_q != 2'd0) begin
			if (byte_s1[7:6] != 2'b10) begin
				broken_d = 1'b1;
			end else if ((limit_q == tes_pkg::LIM_9F) && (byte_s1 > 8'h9F)) begin
				broken_d = 1'b1;
			end else if ((limit_q == tes_pkg::LIM_8F) && (byte_s1 > 8'h8F)) begin
				broken_d = 1'b1;
			end
			limit_d     = tes_pkg::LIM_NONE;
			cont_left_d = cont_left_q - 2'd1;
		end else if (byte_s1 < 8'h80) begin
			// plain ASCII
		end else if (byte_s1 < 8'hC0) begin
			broken_d = 1'b1;
		end else if (byte_s1 < 8'hE0) begin
			cont_left_d = 2'd1;
		end else if (byte_s1 < 8'hF0) begin
			cont_left_d = 2'd2;
			limit_d     = (byte_s1 == 8'hED) ? tes_pkg::LIM_9F : tes_pkg::LIM_NONE;
		end else if (byte_s1 < 8'hF8) begin
			cont_left_d = 2'd3;
			limit_d     = (byte_s1 == 8'hF4) ? tes_pkg::LIM_8F : tes_pkg::LIM_NONE;
		end else begin
			broken_d = 1'b1;
		end

		// Saturating counters
		if (byte_s1[7] && !(&high_total_q)) begin
			high_total_d = high_total_q + COUNT_BITS'(1);
		end
		if (!(&byte_total_q)) begin
			byte_total_d = byte_total_q + COUNT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_byte_q  <= '0;
			byte_total_q <= '0;
			high_total_q <= '0;
			cont_left_q  <= '0;
			limit_q      <= tes_pkg::LIM_NONE;
			broken_q     <= 1'b0;
			bom_prog_q   <= '0;
			flags_q      <= '0;
		end else if (take) begin
			if (last_s1) begin
				// End of file: start the next one from a clean slate
				prev_byte_q  <= '0;
				byte_total_q <= '0;
				high_total_q <= '0;
				cont_left_q  <= '0;
				limit_q      <= tes_pkg::LIM_NONE;
				broken_q     <= 1'b0;
				bom_prog_q   <= '0;
				flags_q      <= '0;
			end else begin
				prev_byte_q  <= byte_s1;
				byte_total_q <= byte_total_d;
				high_total_q <= high_total_d;
				cont_left_q  <= cont_left_d;
				limit_q      <= limit_d;
				broken_q     <= broken_d;
				bom_prog_q   <= bom_prog_d;
				flags_q      <= flags_d;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: final per-file figures, captured on the last byte
	// ---------------------------------------------------------------
	logic                  bom_s2;
	logic                  valid_s2;
	logic [3:0]            flags_s2;
	logic [COUNT_BITS-1:0] high_s2;
	logic [COUNT_BITS-1:0] total_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= 1'b0;
		end else if (!stall) begin
			res_s2 <= vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			bom_s2   <= (bom_prog_d == tes_pkg::BOM_LEN);
			valid_s2 <= !broken_d && (cont_left_d == 2'd0);
			flags_s2 <= flags_d;
			high_s2  <= high_total_d;
			total_s2 <= byte_total_d;
		end
	end

	// ---------------------------------------------------------------
	// Verdict: 100 * high < total, with 100 = 64 + 32 + 4
	// ---------------------------------------------------------------
	logic [PROD_BITS-1:0]             high_x100;
	logic                             few_high;
	tes_pkg::encoding_t               enc;
	logic [tes_pkg::OUT_HIGH_BITS-1:0] high_out;

	assign high_x100 = {1'b0, high_s2, 6'b0} + {2'b0, high_s2, 5'b0} + {5'b0, high_s2, 2'b0};
	assign few_high  = high_x100 < {7'b0, total_s2};

	always_comb begin
		if (bom_s2) begin
			enc = tes_pkg::ENC_UTF8_BOM;
		end else if (valid_s2) begin
			enc = tes_pkg::ENC_UTF8;
		end else if (few_high) begin
			enc = tes_pkg::ENC_FEW_HIGH;
		end else if (flags_s2[tes_pkg::FLAG_GBK]) begin
			enc = tes_pkg::ENC_GBK;
		end else if (flags_s2[tes_pkg::FLAG_BIG5]) begin
			enc = tes_pkg::ENC_BIG5;
		end else if (flags_s2[tes_pkg::FLAG_SJIS]) begin
			enc = tes_pkg::ENC_SJIS;
		end else if (flags_s2[tes_pkg::FLAG_WESTERN]) begin
			enc = tes_pkg::ENC_WIN1252;
		end else begin
			enc = tes_pkg::ENC_SYS_DEFAULT;
		end
	end

	// Clamp or widen the high-byte count to the fixed output width
	generate
		if (COUNT_BITS > tes_pkg::OUT_HIGH_BITS) begin : g_clamp
			assign high_out = (|high_s2[COUNT_BITS-1:tes_pkg::OUT_HIGH_BITS]) ?
			                  '1 : high_s2[tes_pkg::OUT_HIGH_BITS-1:0];
		end else if (COUNT_BITS == tes_pkg::OUT_HIGH_BITS) begin : g_same
			assign high_out = high_s2;
		end else begin : g_widen
			assign high_out = {{(tes_pkg::OUT_HIGH_BITS - COUNT_BITS){1'b0}}, high_s2};
		end
	endgenerate

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	logic [31:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_s2 && !stall) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_s2 && !stall) begin
			out_data_q <= {4'b0, high_out, valid_s2, enc};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
	// High-byte count never passes the byte count
	a_high_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		high_total_q <= byte_total_q)
		else $error("high-byte count exceeds byte count");

	// A second-byte cap only lives inside an open sequence
	a_limit_open: assert property (@(posedge clk) disable iff (!arst_n)
		(limit_q != tes_pkg::LIM_NONE) |-> (cont_left_q != 2'd0))
		else $error("second-byte cap pending with no open sequence");

	// A consumed last byte leaves a fresh file state and a pending verdict
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && last_s1) |=> (byte_total_q == '0) && res_s2)
		else $error("state not cleared after last byte");

	// A verdict in stage 2 while blocked must hold until the output frees
	a_verdict_held: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> res_s2)
		else $error("stalled verdict lost");
`endif

endmodule
